// ===== hdl/sst_pkg.sv =====
// Shared types, token codes and character helpers for the source tokenizer.
`default_nettype none
package sst_pkg;
   localparam int OFFSET_BITS   = 24;
   localparam int POSITION_BITS = 16;
   localparam int WORD_DEPTH    = 9;
   localparam int MAX_RESULTS   = 4;
   localparam int QUEUE_DEPTH   = 8;
   localparam int KIND_BITS     = 6;

   typedef logic [OFFSET_BITS-1:0]   off_type;
   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [KIND_BITS-1:0]     kind_type;

   localparam kind_type K_END = 6'd0,  K_IDENT = 6'd1,  K_NUMBER = 6'd2, K_STRING = 6'd3;
   localparam kind_type K_LET = 6'd4,  K_CONST = 6'd5,  K_FUNCTION = 6'd6, K_RETURN = 6'd7;
   localparam kind_type K_IF = 6'd8,   K_ELSE = 6'd9,   K_WHILE = 6'd10,  K_TRUE = 6'd11;
   localparam kind_type K_FALSE = 6'd12, K_NULL = 6'd13, K_UNDEFINED = 6'd14;
   localparam kind_type K_LPAREN = 6'd15, K_RPAREN = 6'd16, K_LBRACE = 6'd17;
   localparam kind_type K_RBRACE = 6'd18, K_DOT = 6'd19, K_COLON = 6'd20, K_COMMA = 6'd21;
   localparam kind_type K_SEMI = 6'd22, K_PLUS = 6'd23, K_MINUS = 6'd24, K_STAR = 6'd25;
   localparam kind_type K_PERCENT = 6'd26, K_SLASH = 6'd27, K_EQEQ = 6'd28, K_NE = 6'd29;
   localparam kind_type K_LE = 6'd30, K_GE = 6'd31, K_ANDAND = 6'd32, K_OROR = 6'd33;
   localparam kind_type K_BANG = 6'd34, K_ASSIGN = 6'd35, K_LT = 6'd36, K_GT = 6'd37;

   typedef enum logic [4:0] {
      M_IDLE, M_SLASH, M_LINE_CMT, M_BLOCK, M_BLOCK_STAR, M_IDENT,
      M_NUM_ZERO, M_NUM_INT, M_NUM_ZX, M_NUM_HEX, M_NUM_FRAC,
      M_NUM_E, M_NUM_ESIGN, M_NUM_EXP, M_DOT, M_STR, M_STR_ESC, M_PAIR
   } mode_type;

   typedef struct packed {
      kind_type kind;
      off_type  start;
      off_type  length;
      pos_type  line;
      pos_type  column;
      logic     last;
   } token_type;

   typedef logic [7:0] word_type [WORD_DEPTH];

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction
   function automatic logic id_start(logic [7:0] c);
      return is_alpha(c) || c == "_" || c == "$";
   endfunction
   function automatic logic id_char(logic [7:0] c);
      return id_start(c) || is_digit(c);
   endfunction
   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction
   function automatic logic is_exp(logic [7:0] c);
      return c == "e" || c == "E";
   endfunction

   function automatic off_type sat_off(off_type v);
      return (&v) ? v : v + 1'b1;
   endfunction
   function automatic pos_type sat_pos(pos_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic kind_type single_kind(logic [7:0] c);
      kind_type k;
      unique case (c)
         "(": k = K_LPAREN;   ")": k = K_RPAREN;   "{": k = K_LBRACE;  "}": k = K_RBRACE;
         ".": k = K_DOT;      ":": k = K_COLON;    ",": k = K_COMMA;   ";": k = K_SEMI;
         "+": k = K_PLUS;     "-": k = K_MINUS;    "*": k = K_STAR;    "%": k = K_PERCENT;
         "/": k = K_SLASH;    "!": k = K_BANG;     "=": k = K_ASSIGN;  "<": k = K_LT;
         ">": k = K_GT;
         default: k = K_END;
      endcase
      return k;
   endfunction

   function automatic kind_type pair_kind(logic [7:0] first, logic [7:0] c);
      kind_type k;
      k = K_END;
      if (c == "=") begin
         if (first == "=") k = K_EQEQ;
         if (first == "!") k = K_NE;
         if (first == "<") k = K_LE;
         if (first == ">") k = K_GE;
      end
      if (first == "&" && c == "&") k = K_ANDAND;
      if (first == "|" && c == "|") k = K_OROR;
      return k;
   endfunction

   // The text sits right-justified in the literal, so its first byte is the highest one.
   function automatic logic kw_match(word_type wb, off_type len, logic [71:0] txt, int n);
      logic ok;
      ok = (len == off_type'(n));
      for (int i = 0; i < WORD_DEPTH; i++) begin
         if (i < n && wb[i] != txt[8*(n-1-i) +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic kind_type ident_kind(word_type wb, off_type len);
      kind_type k;
      k = K_IDENT;
      if (kw_match(wb, len, 72'("let"), 3))       k = K_LET;
      if (kw_match(wb, len, 72'("const"), 5))     k = K_CONST;
      if (kw_match(wb, len, 72'("function"), 8))  k = K_FUNCTION;
      if (kw_match(wb, len, 72'("return"), 6))    k = K_RETURN;
      if (kw_match(wb, len, 72'("if"), 2))        k = K_IF;
      if (kw_match(wb, len, 72'("else"), 4))      k = K_ELSE;
      if (kw_match(wb, len, 72'("while"), 5))     k = K_WHILE;
      if (kw_match(wb, len, 72'("true"), 4))      k = K_TRUE;
      if (kw_match(wb, len, 72'("false"), 5))     k = K_FALSE;
      if (kw_match(wb, len, 72'("null"), 4))      k = K_NULL;
      if (kw_match(wb, len, 72'("undefined"), 9)) k = K_UNDEFINED;
      return k;
   endfunction

   function automatic token_type make_tok(kind_type k, off_type s, off_type l,
                                          pos_type ln, pos_type col);
      token_type t;
      t.kind = k; t.start = s; t.length = l; t.line = ln; t.column = col; t.last = 1'b0;
      return t;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/script_source_tokenizer.sv =====
// Top level of the source tokenizer: per-byte scanner and token output queue.
// One source byte is taken per beat and scanned in the same cycle; the tokens it
// completes (zero to four) go into an eight-entry output queue that drains one token
// per cycle while rsp_ready is high. A new byte is taken whenever at most four tokens
// are queued, so with an output that keeps up the block sustains one byte per cycle;
// the input stalls only while a run of bytes completes tokens faster than the output
// drains them. An end-of-input beat flushes any pending token, emits the end token
// and returns the scanner to its reset state.
`default_nettype none
module script_source_tokenizer import sst_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_in_byte,
   input  wire logic                    req_end_of_input,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [KIND_BITS-1:0]         rsp_token_kind,
   output logic [OFFSET_BITS-1:0]       rsp_token_start,
   output logic [OFFSET_BITS-1:0]       rsp_token_length,
   output logic [POSITION_BITS-1:0]     rsp_token_line,
   output logic [POSITION_BITS-1:0]     rsp_token_column,
   output logic                         rsp_last_of_run
);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);

   mode_type mode_ff, mode_in;
   off_type  off_ff, off_in, tok_ff, tok_in, pstart_ff, pstart_in, mark_ff, mark_in;
   pos_type  line_ff, line_in, col_ff, col_in, pline_ff, pline_in, pcol_ff, pcol_in;
   logic [7:0] quote_ff, quote_in;
   word_type wb_ff, wb_in;
   logic [7:0] lb_ff [2];
   logic [7:0] lb_in [2];
   off_type lboff_ff [2];
   off_type lboff_in [2];
   pos_type lbline_ff [2];
   pos_type lbline_in [2];
   pos_type lbcol_ff [2];
   pos_type lbcol_in [2];

   token_type res [MAX_RESULTS];
   logic [2:0] nres;

   token_type queue_ff [QUEUE_DEPTH];
   token_type queue_in [QUEUE_DEPTH];
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic accept, pop;
   assign req_ready = cnt_ff <= CNT_BITS'(QUEUE_DEPTH - MAX_RESULTS);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = cnt_ff != '0;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      logic [7:0] c;
      logic redo_idle, redo_ident, esc;
      kind_type k;
      c = req_in_byte;
      redo_idle = 1'b0; redo_ident = 1'b0; esc = 1'b0;
      k = K_END;
      mode_in = mode_ff; off_in = off_ff; tok_in = tok_ff; pstart_in = pstart_ff;
      mark_in = mark_ff; line_in = line_ff; col_in = col_ff; pline_in = pline_ff;
      pcol_in = pcol_ff; quote_in = quote_ff; wb_in = wb_ff;
      lb_in = lb_ff; lboff_in = lboff_ff; lbline_in = lbline_ff; lbcol_in = lbcol_ff;
      nres = '0;
      for (int i = 0; i < MAX_RESULTS; i++) res[i] = make_tok(K_END, '0, '0, '0, '0);

      if (req_end_of_input) begin
         unique case (mode_ff)
            M_SLASH: begin
               res[nres[1:0]] = make_tok(K_SLASH, pstart_ff, off_type'(1), pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            M_IDENT: begin
               res[nres[1:0]] = make_tok(ident_kind(wb_ff, tok_ff), pstart_ff, tok_ff,
                                         pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            M_NUM_ZERO, M_NUM_INT, M_NUM_HEX, M_NUM_FRAC, M_NUM_EXP: begin
               res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, tok_ff, pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            M_NUM_ZX, M_NUM_E, M_NUM_ESIGN: begin
               res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, mark_ff, pline_ff, pcol_ff);
               nres = nres + 1'b1;
               // The backed-off exponent letter or x is a one-byte identifier.
               res[nres[1:0]] = make_tok(K_IDENT, lboff_ff[0], off_type'(1),
                                         lbline_ff[0], lbcol_ff[0]);
               nres = nres + 1'b1;
               if (mode_ff == M_NUM_ESIGN) begin
                  res[nres[1:0]] = make_tok(single_kind(lb_ff[1]), lboff_ff[1], off_type'(1),
                                            lbline_ff[1], lbcol_ff[1]);
                  nres = nres + 1'b1;
               end
            end
            M_DOT: begin
               res[nres[1:0]] = make_tok(K_DOT, pstart_ff, off_type'(1), pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            M_STR, M_STR_ESC: begin
               res[nres[1:0]] = make_tok(K_STRING, pstart_ff, tok_ff, pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            M_PAIR: begin
               res[nres[1:0]] = make_tok(single_kind(lb_ff[0]), pstart_ff, off_type'(1),
                                         pline_ff, pcol_ff);
               nres = nres + 1'b1;
            end
            default: ;
         endcase
         res[nres[1:0]] = make_tok(K_END, off_ff, '0, line_ff, col_ff);
         nres = nres + 1'b1;
         mode_in = M_IDLE; off_in = '0; line_in = pos_type'(1); col_in = pos_type'(1);
         pstart_in = '0; pline_in = pos_type'(1); pcol_in = pos_type'(1);
         tok_in = '0; mark_in = '0; quote_in = '0;
      end else begin
         unique case (mode_ff)
            M_IDLE: redo_idle = 1'b1;
            M_SLASH: begin
               if (c == "/") mode_in = M_LINE_CMT;
               else if (c == "*") mode_in = M_BLOCK;
               else begin
                  res[nres[1:0]] = make_tok(K_SLASH, pstart_ff, off_type'(1), pline_ff,
                                            pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_LINE_CMT: if (c == 8'h0a) mode_in = M_IDLE;
            M_BLOCK: if (c == "*") mode_in = M_BLOCK_STAR;
            M_BLOCK_STAR: begin
               if (c == "/") mode_in = M_IDLE;
               else if (c != "*") mode_in = M_BLOCK;
            end
            M_IDENT: begin
               if (id_char(c)) begin
                  if (tok_ff < off_type'(WORD_DEPTH))
                     wb_in[tok_ff[$clog2(WORD_DEPTH)-1:0]] = c;
                  tok_in = sat_off(tok_ff);
               end else begin
                  res[nres[1:0]] = make_tok(ident_kind(wb_ff, tok_ff), pstart_ff, tok_ff,
                                            pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC: begin
               if (is_digit(c)) begin
                  if (mode_ff == M_NUM_ZERO) mode_in = M_NUM_INT;
                  tok_in = sat_off(tok_ff);
               end else if (c == "." && mode_ff != M_NUM_FRAC) begin
                  mode_in = M_NUM_FRAC;
                  tok_in = sat_off(tok_ff);
               end else if (is_exp(c) || ((c == "x" || c == "X") && mode_ff == M_NUM_ZERO))
               begin
                  lb_in[0] = c; lboff_in[0] = off_ff; lbline_in[0] = line_ff;
                  lbcol_in[0] = col_ff; mark_in = tok_ff;
                  mode_in = is_exp(c) ? M_NUM_E : M_NUM_ZX;
                  tok_in = sat_off(tok_ff);
               end else begin
                  res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, tok_ff, pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_NUM_ZX, M_NUM_HEX: begin
               if (is_hex(c)) begin
                  mode_in = M_NUM_HEX;
                  tok_in = sat_off(tok_ff);
               end else if (mode_ff == M_NUM_ZX) redo_ident = 1'b1;
               else begin
                  res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, tok_ff, pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_NUM_E: begin
               if (is_digit(c)) begin
                  mode_in = M_NUM_EXP;
                  tok_in = sat_off(tok_ff);
               end else if (c == "+" || c == "-") begin
                  lb_in[1] = c; lboff_in[1] = off_ff; lbline_in[1] = line_ff;
                  lbcol_in[1] = col_ff;
                  mode_in = M_NUM_ESIGN;
                  tok_in = sat_off(tok_ff);
               end else redo_ident = 1'b1;
            end
            M_NUM_ESIGN: begin
               if (is_digit(c)) begin
                  mode_in = M_NUM_EXP;
                  tok_in = sat_off(tok_ff);
               end else begin
                  res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, mark_ff, pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  res[nres[1:0]] = make_tok(K_IDENT, lboff_ff[0], off_type'(1),
                                            lbline_ff[0], lbcol_ff[0]);
                  nres = nres + 1'b1;
                  res[nres[1:0]] = make_tok(single_kind(lb_ff[1]), lboff_ff[1], off_type'(1),
                                            lbline_ff[1], lbcol_ff[1]);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_NUM_EXP: begin
               if (is_digit(c)) tok_in = sat_off(tok_ff);
               else begin
                  res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, tok_ff, pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(c)) begin
                  mode_in = M_NUM_FRAC;
                  tok_in = off_type'(2);
               end else begin
                  res[nres[1:0]] = make_tok(K_DOT, pstart_ff, off_type'(1), pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            M_STR: begin
               if (c == quote_ff) begin
                  res[nres[1:0]] = make_tok(K_STRING, pstart_ff, tok_ff, pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  if (c == "\\") mode_in = M_STR_ESC;
                  tok_in = sat_off(tok_ff);
               end
            end
            M_STR_ESC: begin
               esc = 1'b1;
               tok_in = sat_off(tok_ff);
               mode_in = M_STR;
            end
            M_PAIR: begin
               k = pair_kind(lb_ff[0], c);
               if (k != K_END) begin
                  res[nres[1:0]] = make_tok(k, pstart_ff, off_type'(2), pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  mode_in = M_IDLE;
               end else begin
                  res[nres[1:0]] = make_tok(single_kind(lb_ff[0]), pstart_ff, off_type'(1),
                                            pline_ff, pcol_ff);
                  nres = nres + 1'b1;
                  redo_idle = 1'b1;
               end
            end
            default: redo_idle = 1'b1;
         endcase

         // A dangling exponent letter or x is an identifier; an id byte extends it.
         if (redo_ident) begin
            res[nres[1:0]] = make_tok(K_NUMBER, pstart_ff, mark_ff, pline_ff, pcol_ff);
            nres = nres + 1'b1;
            pstart_in = lboff_ff[0]; pline_in = lbline_ff[0]; pcol_in = lbcol_ff[0];
            wb_in[0] = lb_ff[0];
            if (id_char(c)) begin
               wb_in[1] = c;
               tok_in = off_type'(2);
               mode_in = M_IDENT;
            end else begin
               res[nres[1:0]] = make_tok(K_IDENT, lboff_ff[0], off_type'(1),
                                         lbline_ff[0], lbcol_ff[0]);
               nres = nres + 1'b1;
               redo_idle = 1'b1;
            end
         end

         if (redo_idle) begin
            mode_in = M_IDLE;
            if (!is_space(c)) begin
               pstart_in = off_ff; pline_in = line_ff; pcol_in = col_ff;
               tok_in = off_type'(1);
               if (c == "/") mode_in = M_SLASH;
               else if (id_start(c)) begin
                  wb_in[0] = c;
                  mode_in = M_IDENT;
               end else if (c == "0") mode_in = M_NUM_ZERO;
               else if (is_digit(c)) mode_in = M_NUM_INT;
               else if (c == ".") mode_in = M_DOT;
               else if (c == "\"" || c == "'") begin
                  quote_in = c;
                  pstart_in = sat_off(off_ff);
                  tok_in = '0;
                  mode_in = M_STR;
               end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
                            c == "|") begin
                  lb_in[0] = c;
                  mode_in = M_PAIR;
               end else begin
                  res[nres[1:0]] = make_tok(single_kind(c), off_ff, off_type'(1), line_ff,
                                            col_ff);
                  nres = nres + 1'b1;
               end
            end
         end

         off_in = sat_off(off_ff);
         if (c == 8'h0a && !esc) begin
            line_in = sat_pos(line_ff);
            col_in = pos_type'(1);
         end else col_in = sat_pos(col_ff);
      end
      if (nres != '0) res[nres[1:0] - 2'd1].last = 1'b1;
   end

   // Output queue: the head is always entry zero, new tokens land behind the survivors.
   always_comb begin
      logic [CNT_BITS-1:0] base;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) queue_in[i] = queue_ff[i+1];
         else queue_in[i] = queue_ff[i];
      end
      base = cnt_ff - CNT_BITS'(pop);
      cnt_in = base;
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (3'(i) < nres) queue_in[IDX_BITS'(base + CNT_BITS'(i))] = res[i];
         end
         cnt_in = base + CNT_BITS'(nres);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         off_ff <= '0; tok_ff <= '0; pstart_ff <= '0; mark_ff <= '0;
         line_ff <= pos_type'(1); col_ff <= pos_type'(1);
         pline_ff <= pos_type'(1); pcol_ff <= pos_type'(1);
         quote_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            off_ff <= off_in; tok_ff <= tok_in; pstart_ff <= pstart_in; mark_ff <= mark_in;
            line_ff <= line_in; col_ff <= col_in; pline_ff <= pline_in; pcol_ff <= pcol_in;
            quote_ff <= quote_in;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wb_ff <= wb_in;
         lb_ff <= lb_in; lboff_ff <= lboff_in; lbline_ff <= lbline_in; lbcol_ff <= lbcol_in;
      end
      queue_ff <= queue_in;
   end

   assign rsp_token_kind   = queue_ff[0].kind;
   assign rsp_token_start  = queue_ff[0].start;
   assign rsp_token_length = queue_ff[0].length;
   assign rsp_token_line   = queue_ff[0].line;
   assign rsp_token_column = queue_ff[0].column;
   assign rsp_last_of_run  = queue_ff[0].last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(QUEUE_DEPTH)) else $error("output queue overflow");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_input |=> mode_ff == M_IDLE && off_ff == '0)
      else $error("end beat did not restart the scanner");
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_input |=> rsp_valid)
      else $error("end beat produced no token");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("queue not empty after reset");
endmodule
`default_nettype wire
